/* rtl/core/fla_pkg.sv */
`default_nettype none

package fla_pkg;

    localparam int IDX_W = 10;
    localparam int TOT_W = 32;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_EXHAUSTED = 1'b1;

endpackage

`default_nettype wire

/* rtl/core/fla_link_mem.sv */
`default_nettype none

module fla_link_mem #(
    parameter int DEPTH = 1024,
    parameter int DATA_W = 11,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/free_list_cell_allocator.sv */
// channel  direction  handshake                  beat
// request  in         i_in_valid / o_in_stall    i_opcode, i_cell_index
// result   out        o_out_valid / i_out_stall  o_granted_index, o_status,
//                                                o_alloc_total, o_free_total
//
// a free or an exhausted allocate gives its result in the cycle after it is taken;
// an allocate from a non-empty list reads the head's link from the link memory, then pops it.
// an allocate on an empty list first chains the new cells, one link memory
// write per new cell (at most the old capacity), then reads the new head.
// after reset the initial chain of min(INITIAL_CELLS, MAX_CELLS) entries is written
// one entry a cycle, with the request side stalled.
// a result waits in the output register while the result side stalls; no new
// request is taken until that register can be refilled.
`default_nettype none

module free_list_cell_allocator #(
    parameter int MAX_CELLS = 1024,
    parameter int INITIAL_CELLS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_opcode,
    input  wire logic [fla_pkg::IDX_W-1:0]     i_cell_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [fla_pkg::IDX_W-1:0]     o_granted_index,
    output logic                               o_status,
    output logic      [fla_pkg::TOT_W-1:0]     o_alloc_total,
    output logic      [fla_pkg::TOT_W-1:0]     o_free_total
);

    localparam int IW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CW = $clog2(MAX_CELLS + 1);
    localparam int PW = (CW > fla_pkg::IDX_W) ? CW : fla_pkg::IDX_W;
    localparam int START = (INITIAL_CELLS > MAX_CELLS) ? MAX_CELLS : INITIAL_CELLS;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_GROW,
        S_FETCH,
        S_POP
    } t_state;

    t_state                     r_state, n_state;
    logic [IW-1:0]              r_head, n_head;
    logic                       r_head_valid, n_head_valid;
    logic [CW-1:0]              r_committed, n_committed;
    logic [CW-1:0]              r_ptr, n_ptr;
    logic [CW-1:0]              r_limit, n_limit;
    logic [fla_pkg::TOT_W-1:0]  r_alloc_cnt, n_alloc_cnt;
    logic [fla_pkg::TOT_W-1:0]  r_free_cnt, n_free_cnt;
    logic                       r_out_valid, n_out_valid;
    logic [fla_pkg::IDX_W-1:0]  r_granted, n_granted;
    logic                       r_status, n_status;

    logic                       mem_we;
    logic [IW-1:0]              mem_waddr;
    logic [IW:0]                mem_wdata;
    logic                       mem_re;
    logic [IW-1:0]              mem_raddr;
    logic [IW:0]                mem_rdata;

    logic                       slot_free;
    logic                       accept;
    logic [PW-1:0]              idx_p;
    logic                       idx_ok;
    logic [CW:0]                doubled;
    logic [CW:0]                grown;
    logic [CW-1:0]              ptr_next;
    logic                       chain_end;
    logic                       rd_end;
    logic [IW-1:0]              rd_link;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && slot_free);
    assign accept = i_in_valid && !o_in_stall;

    assign idx_p = PW'(i_cell_index);
    assign idx_ok = idx_p < PW'(r_committed);
    assign doubled = {r_committed, 1'b0};
    assign grown = (doubled > (CW+1)'(MAX_CELLS)) ? (CW+1)'(MAX_CELLS) : doubled;

    assign ptr_next = r_ptr + 1'b1;
    assign chain_end = (ptr_next == r_limit);
    assign rd_end = mem_rdata[IW];
    assign rd_link = mem_rdata[IW-1:0];

    fla_link_mem #(
        .DEPTH  (MAX_CELLS),
        .DATA_W (IW + 1)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_committed  = r_committed;
        n_ptr        = r_ptr;
        n_limit      = r_limit;
        n_alloc_cnt  = r_alloc_cnt;
        n_free_cnt   = r_free_cnt;
        n_out_valid  = r_out_valid && i_out_stall;
        n_granted    = r_granted;
        n_status     = r_status;
        mem_we       = 1'b0;
        mem_waddr    = r_ptr[IW-1:0];
        mem_wdata    = {chain_end, chain_end ? IW'(0) : ptr_next[IW-1:0]};
        mem_re       = 1'b0;
        mem_raddr    = r_head;

        unique case (r_state)
            S_INIT, S_GROW: begin
                // one chain link per cycle, ascending
                mem_we = 1'b1;
                if (chain_end) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_FETCH;
                end else begin
                    n_ptr = ptr_next;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == fla_pkg::OP_FREE) begin
                        n_out_valid = 1'b1;
                        n_granted   = '0;
                        n_status    = fla_pkg::ST_OK;
                        if (idx_ok) begin
                            mem_we       = 1'b1;
                            mem_waddr    = idx_p[IW-1:0];
                            mem_wdata    = {!r_head_valid, r_head_valid ? r_head : IW'(0)};
                            n_head       = idx_p[IW-1:0];
                            n_head_valid = 1'b1;
                            n_free_cnt   = r_free_cnt + 1'b1;
                        end
                    end else if (r_head_valid) begin
                        mem_re  = 1'b1;
                        n_state = S_POP;
                    end else if (r_committed >= CW'(MAX_CELLS)) begin
                        n_out_valid = 1'b1;
                        n_granted   = '0;
                        n_status    = fla_pkg::ST_EXHAUSTED;
                    end else begin
                        n_ptr        = r_committed;
                        n_limit      = CW'(grown);
                        n_head       = r_committed[IW-1:0];
                        n_head_valid = 1'b1;
                        n_committed  = CW'(grown);
                        n_state      = S_GROW;
                    end
                end
            end
            S_FETCH: begin
                mem_re  = 1'b1;
                n_state = S_POP;
            end
            S_POP: begin
                if (slot_free) begin
                    // the granted cell's link is cleared
                    mem_we       = 1'b1;
                    mem_waddr    = r_head;
                    mem_wdata    = '0;
                    n_out_valid  = 1'b1;
                    n_granted    = fla_pkg::IDX_W'(r_head);
                    n_status     = fla_pkg::ST_OK;
                    n_head_valid = !rd_end;
                    n_head       = rd_end ? IW'(0) : rd_link;
                    n_alloc_cnt  = r_alloc_cnt + 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_head       <= '0;
            r_head_valid <= 1'b1;
            r_committed  <= CW'(START);
            r_ptr        <= '0;
            r_limit      <= CW'(START);
            r_alloc_cnt  <= '0;
            r_free_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_head_valid <= n_head_valid;
            r_committed  <= n_committed;
            r_ptr        <= n_ptr;
            r_limit      <= n_limit;
            r_alloc_cnt  <= n_alloc_cnt;
            r_free_cnt   <= n_free_cnt;
            r_out_valid  <= n_out_valid;
        end
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted_index = r_granted;
    assign o_status        = r_status;
    assign o_alloc_total   = r_alloc_cnt;
    assign o_free_total    = r_free_cnt;

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> r_head_valid)
        else $error("pop with empty free list");

    a_capacity_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_committed <= CW'(MAX_CELLS)) && (r_committed != '0))
        else $error("committed capacity out of range");

    a_chain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_GROW) || (r_state == S_INIT)) |-> (r_ptr < r_limit))
        else $error("chain pointer past limit");

    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alloc_cnt != $past(r_alloc_cnt)) |->
            (r_out_valid && (r_alloc_cnt == $past(r_alloc_cnt) + 1'b1)
             && (r_status == fla_pkg::ST_OK)))
        else $error("allocate count moved without a granted beat");

endmodule

`default_nettype wire
